### design/mdu_pkg.sv
package mdu_pkg;

  typedef enum logic [1:0] {
    FN_MUL  = 2'd0,
    FN_IMUL = 2'd1,
    FN_DIV  = 2'd2,
    FN_IDIV = 2'd3
  } func_t;

  localparam int unsigned DivSteps = 4;

  typedef struct packed {
    func_t       func;
    logic        word;
    logic [15:0] ax;
    logic [15:0] dx;
    logic        neg_q;
    logic        neg_r;
    logic        err_pre;
    logic [31:0] prod;
  } side_t;

endpackage

### design/mdu_prep.sv
module mdu_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  input  logic               in_word_size,
  input  logic [15:0]        in_operand,
  input  logic [15:0]        in_ax_in,
  input  logic [15:0]        in_dx_in,
  output logic               valid_r,
  output logic [15:0]        rem_r,
  output logic [15:0]        quo_r,
  output logic [15:0]        dvs_r,
  output mdu_pkg::side_t     side_r,
  output logic signed [16:0] mul_a_r,
  output logic signed [16:0] mul_b_r
);
  import mdu_pkg::*;

  func_t       fn;
  logic        sgn;
  logic        dneg;
  logic        sneg;
  logic [31:0] dd;
  logic [31:0] dd_mag;
  logic [15:0] src;
  logic [15:0] dvs_nxt;
  side_t       side_nxt;
  logic [15:0] acc;

  always_comb begin
    fn   = func_t'(in_func);
    sgn  = (fn == FN_IMUL) || (fn == FN_IDIV);
    src  = in_word_size ? in_operand : {8'h00, in_operand[7:0]};
    acc  = in_word_size ? in_ax_in : {8'h00, in_ax_in[7:0]};
    sneg = sgn && (in_word_size ? in_operand[15] : in_operand[7]);
    dneg = sgn && (in_word_size ? in_dx_in[15] : in_ax_in[15]);
    dd   = in_word_size ? {in_dx_in, in_ax_in} : {16'h0000, in_ax_in};
    if (dneg) begin
      dd_mag = in_word_size ? (32'd0 - dd) : {16'h0000, 16'd0 - in_ax_in};
    end else begin
      dd_mag = dd;
    end
    if (sneg) begin
      dvs_nxt = in_word_size ? (16'd0 - in_operand) : {8'h00, 8'd0 - in_operand[7:0]};
    end else begin
      dvs_nxt = src;
    end
    side_nxt.func    = fn;
    side_nxt.word    = in_word_size;
    side_nxt.ax      = in_ax_in;
    side_nxt.dx      = in_dx_in;
    side_nxt.neg_q   = dneg ^ sneg;
    side_nxt.neg_r   = dneg;
    side_nxt.err_pre = (dvs_nxt == 16'd0) || (dd_mag[31:16] >= dvs_nxt);
    side_nxt.prod    = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= dd_mag[31:16];
      quo_r   <= dd_mag[15:0];
      dvs_r   <= dvs_nxt;
      side_r  <= side_nxt;
      mul_a_r <= (fn == FN_IMUL && !in_word_size) ? {{9{src[7]}}, src[7:0]} :
                 (sgn ? {src[15], src} : {1'b0, src});
      mul_b_r <= (fn == FN_IMUL) ?
                 (in_word_size ? {acc[15], acc} : {{9{acc[7]}}, acc[7:0]}) :
                 {1'b0, acc};
    end
  end

endmodule

### design/mdu_div_stage.sv
module mdu_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_in,
  input  logic [15:0]    rem_in,
  input  logic [15:0]    quo_in,
  input  logic [15:0]    dvs_in,
  input  mdu_pkg::side_t side_in,
  output logic           valid_r,
  output logic [15:0]    rem_r,
  output logic [15:0]    quo_r,
  output logic [15:0]    dvs_r,
  output mdu_pkg::side_t side_r
);
  import mdu_pkg::*;

  logic [15:0] rem_nxt;
  logic [15:0] quo_nxt;
  logic [16:0] trial;

  // restoring division, one quotient bit per step, quotient shifts into quo
  always_comb begin
    rem_nxt = rem_in;
    quo_nxt = quo_in;
    trial   = 17'd0;
    for (int i = 0; i < DivSteps; i++) begin
      trial   = {rem_nxt, quo_nxt[15]};
      quo_nxt = {quo_nxt[14:0], 1'b0};
      if (trial >= {1'b0, dvs_in}) begin
        trial      = trial - {1'b0, dvs_in};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dvs_r  <= dvs_in;
      side_r <= side_in;
    end
  end

endmodule

### design/mdu_post.sv
module mdu_post (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_in,
  input  logic [15:0]    rem_in,
  input  logic [15:0]    quo_in,
  input  mdu_pkg::side_t side_in,
  output logic           out_valid,
  output logic [15:0]    out_ax_out,
  output logic [15:0]    out_dx_out,
  output logic           out_carry_overflow,
  output logic           out_flags_update,
  output logic           out_divide_error
);
  import mdu_pkg::*;

  logic [15:0] ax_nxt;
  logic [15:0] dx_nxt;
  logic        cof_nxt;
  logic        fupd_nxt;
  logic        derr_nxt;
  logic [15:0] q;
  logic [15:0] r;
  logic [31:0] p;
  logic        ovf;

  always_comb begin
    p        = side_in.prod;
    ax_nxt   = side_in.ax;
    dx_nxt   = side_in.dx;
    cof_nxt  = 1'b0;
    fupd_nxt = 1'b0;
    derr_nxt = 1'b0;
    q        = side_in.neg_q ? (16'd0 - quo_in) : quo_in;
    r        = side_in.neg_r ? (16'd0 - rem_in) : rem_in;
    ovf      = 1'b0;
    case (side_in.func)
      FN_MUL: begin
        fupd_nxt = 1'b1;
        cof_nxt  = side_in.word ? (p[31:16] != 16'd0) : (p[15:8] != 8'd0);
      end
      FN_IMUL: begin
        fupd_nxt = 1'b1;
        cof_nxt  = side_in.word ? (p[31:16] != {16{p[15]}}) : (p[15:8] != {8{p[7]}});
      end
      FN_DIV: begin
        ovf = !side_in.word && (quo_in[15:8] != 8'd0);
      end
      FN_IDIV: begin
        if (side_in.word) begin
          ovf = side_in.neg_q ? (quo_in > 16'h8000) : (quo_in > 16'h7FFF);
        end else begin
          ovf = side_in.neg_q ? (quo_in > 16'h0080) : (quo_in > 16'h007F);
        end
      end
      default: begin
        ovf = 1'b0;
      end
    endcase
    if (fupd_nxt) begin
      ax_nxt = p[15:0];
      if (side_in.word) begin
        dx_nxt = p[31:16];
      end
    end else if (side_in.err_pre || ovf) begin
      derr_nxt = 1'b1;
    end else if (side_in.word) begin
      ax_nxt = q;
      dx_nxt = r;
    end else begin
      ax_nxt = {r[7:0], q[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ax_out         <= ax_nxt;
      out_dx_out         <= dx_nxt;
      out_carry_overflow <= cof_nxt;
      out_flags_update   <= fupd_nxt;
      out_divide_error   <= derr_nxt;
    end
  end

endmodule

### design/x86_multiply_divide_unit.sv
// Accept to result valid passes prep, 4 divide stages and result, each registered.
// Throughput: one item per cycle unless stalled; 4 quotient bits retire per stage.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
// Reset: synchronous active-low rst_n clears all stage valid bits.
module x86_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_word_size,
  input  logic [15:0] in_operand,
  input  logic [15:0] in_ax_in,
  input  logic [15:0] in_dx_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_ax_out,
  output logic [15:0] out_dx_out,
  output logic        out_carry_overflow,
  output logic        out_flags_update,
  output logic        out_divide_error
);
  import mdu_pkg::*;

  localparam int unsigned NStg = 4;

  logic               en;
  logic               v     [NStg+1];
  logic [15:0]        rem   [NStg+1];
  logic [15:0]        quo   [NStg+1];
  logic [15:0]        dvs   [NStg+1];
  side_t              side  [NStg+1];
  side_t              side0;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  mdu_prep u_prep (
    .clk, .rst_n, .en, .in_valid, .in_func, .in_word_size, .in_operand,
    .in_ax_in, .in_dx_in,
    .valid_r(v[0]), .rem_r(rem[0]), .quo_r(quo[0]), .dvs_r(dvs[0]),
    .side_r(side0), .mul_a_r(mul_a), .mul_b_r(mul_b)
  );

  always_comb begin
    prod         = mul_a * mul_b;
    side[0]      = side0;
    side[0].prod = prod[31:0];
  end

  for (genvar g = 0; g < NStg; g++) begin : g_div
    mdu_div_stage u_stage (
      .clk, .rst_n, .en,
      .valid_in(v[g]), .rem_in(rem[g]), .quo_in(quo[g]), .dvs_in(dvs[g]),
      .side_in(side[g]),
      .valid_r(v[g+1]), .rem_r(rem[g+1]), .quo_r(quo[g+1]), .dvs_r(dvs[g+1]),
      .side_r(side[g+1])
    );
  end

  mdu_post u_post (
    .clk, .rst_n, .en,
    .valid_in(v[NStg]), .rem_in(rem[NStg]), .quo_in(quo[NStg]), .side_in(side[NStg]),
    .out_valid, .out_ax_out, .out_dx_out, .out_carry_overflow, .out_flags_update,
    .out_divide_error
  );

`ifndef SYNTHESIS
  a_err_not_mul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_flags_update && out_divide_error))
    else $error("divide error on a multiply item");

  a_cof_mul_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flags_update |-> !out_carry_overflow)
    else $error("carry/overflow set on a divide item");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v[NStg]) && $stable(quo[NStg]))
    else $error("pipeline advanced during stall");
`endif

endmodule

### verif/x86_multiply_divide_unit_checker.sv
module x86_multiply_divide_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_word_size,
  input  logic [15:0] in_operand,
  input  logic [15:0] in_ax_in,
  input  logic [15:0] in_dx_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_ax_out,
  input  logic [15:0] out_dx_out,
  input  logic        out_carry_overflow,
  input  logic        out_flags_update,
  input  logic        out_divide_error,
  output int          fail_count,
  output int          pending
);
  import mdu_pkg::*;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] dx;
    logic        cof;
    logic        fupd;
    logic        derr;
  } mdu_result_t;

  mdu_result_t pending_results[$];

  function automatic mdu_result_t mdu_predict(func_t fn, logic word, logic [15:0] opnd,
                                              logic [15:0] ax, logic [15:0] dx);
    mdu_result_t r;
    longint unsigned src, acc, prod, dvd, q, rm, mask;
    longint sa, sb, sp, sd, ss, sq, sr, lim;
    int n;
    n = word ? 16 : 8;
    mask = word ? 64'hFFFF : 64'hFF;
    src = opnd & mask;
    acc = ax & mask;
    r = '{ax: ax, dx: dx, cof: 1'b0, fupd: 1'b0, derr: 1'b0};
    if (fn == FN_MUL || fn == FN_IMUL) begin
      r.fupd = 1'b1;
      if (fn == FN_MUL) begin
        prod = src * acc;
        r.cof = (prod >> n) != 0;
      end else begin
        sa = word ? longint'($signed(src[15:0])) : longint'($signed(src[7:0]));
        sb = word ? longint'($signed(acc[15:0])) : longint'($signed(acc[7:0]));
        sp = sa * sb;
        prod = sp;
        prod = prod & ((mask << n) | mask);
        sa = word ? longint'($signed(prod[15:0])) : longint'($signed(prod[7:0]));
        r.cof = sa != sp;
      end
      r.ax = prod[15:0];
      if (word) r.dx = prod[31:16];
    end else begin
      dvd = word ? {dx, ax} : ax;
      if (src == 0) begin
        r.derr = 1'b1;
      end else begin
        if (fn == FN_DIV) begin
          q = dvd / src;
          rm = dvd % src;
          r.derr = q > mask;
        end else begin
          sd = word ? longint'($signed(dvd[31:0])) : longint'($signed(dvd[15:0]));
          ss = word ? longint'($signed(src[15:0])) : longint'($signed(src[7:0]));
          sq = sd / ss;
          sr = sd % ss;
          lim = 64'sd1 <<< (n - 1);
          r.derr = (sq >= lim) || (sq < -lim);
          q = sq;
          rm = sr;
        end
        if (!r.derr) begin
          if (word) begin
            r.ax = q[15:0];
            r.dx = rm[15:0];
          end else begin
            r.ax = {rm[7:0], q[7:0]};
          end
        end
      end
    end
    return r;
  endfunction

  assign pending = pending_results.size();

  always @(posedge clk) begin
    mdu_result_t e;
    if (!rst_n) begin
      pending_results.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        pending_results.push_back(mdu_predict(func_t'(in_func), in_word_size, in_operand,
                                              in_ax_in, in_dx_in));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item ax=%h dx=%h", $time, out_ax_out, out_dx_out);
          fail_count <= fail_count + 1;
        end else begin
          e = pending_results.pop_front();
          if (e != {out_ax_out, out_dx_out, out_carry_overflow, out_flags_update,
                    out_divide_error}) begin
            $display("%0t: mismatch exp ax=%h dx=%h cof=%b fu=%b de=%b",
                     $time, e.ax, e.dx, e.cof, e.fupd, e.derr,
                     " act ax=%h dx=%h cof=%b fu=%b de=%b",
                     out_ax_out, out_dx_out,
                     out_carry_overflow, out_flags_update, out_divide_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/x86_multiply_divide_unit_tb.sv
module x86_multiply_divide_unit_tb;
  import mdu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FN_MUL;
  logic        in_word_size = 1'b0;
  logic [15:0] in_operand = '0;
  logic [15:0] in_ax_in = '0;
  logic [15:0] in_dx_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_ax_out;
  logic [15:0] out_dx_out;
  logic        out_carry_overflow;
  logic        out_flags_update;
  logic        out_divide_error;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          item_num = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  x86_multiply_divide_unit dut (.*);
  x86_multiply_divide_unit_checker chk (.*);

  // directed items: func, word, operand, ax, dx
  logic [50:0] directed[$] = '{
    {FN_MUL, 1'b0, 16'hFFFF, 16'h00FF, 16'h1234},
    {FN_MUL, 1'b0, 16'h0002, 16'h0003, 16'h0000},
    {FN_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000},
    {FN_MUL, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF},
    {FN_IMUL, 1'b0, 16'h0080, 16'h0080, 16'h0000},
    {FN_IMUL, 1'b0, 16'h00FF, 16'h0005, 16'h0000},
    {FN_IMUL, 1'b1, 16'h8000, 16'h8000, 16'h0000},
    {FN_IMUL, 1'b1, 16'hFFFF, 16'h7FFF, 16'h0000},
    {FN_DIV, 1'b0, 16'hFF00, 16'h1234, 16'hBEEF},
    {FN_DIV, 1'b0, 16'h0001, 16'h0100, 16'h0000},
    {FN_DIV, 1'b0, 16'h00FF, 16'hFFFF, 16'h0000},
    {FN_DIV, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFE},
    {FN_DIV, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF},
    {FN_DIV, 1'b1, 16'h0007, 16'h1234, 16'h0001},
    {FN_IDIV, 1'b0, 16'h00FF, 16'h0080, 16'h0000},
    {FN_IDIV, 1'b0, 16'h00FF, 16'hFF80, 16'h0000},
    {FN_IDIV, 1'b0, 16'h0003, 16'hFFF9, 16'h0000},
    {FN_IDIV, 1'b0, 16'h0000, 16'h0011, 16'h0000},
    {FN_IDIV, 1'b1, 16'hFFFF, 16'h0000, 16'h8000},
    {FN_IDIV, 1'b1, 16'h0001, 16'h8000, 16'hFFFF},
    {FN_IDIV, 1'b1, 16'hFFFD, 16'h0007, 16'h0000},
    {FN_IDIV, 1'b1, 16'h0002, 16'h0000, 16'h0001}
  };

  task automatic next_item(output logic [50:0] it);
    logic [15:0] opnd, ax, dx;
    logic [1:0] fn;
    logic w;
    fn = $urandom_range(0, 3);
    w = $urandom_range(0, 1);
    opnd = $urandom;
    ax = $urandom;
    dx = $urandom;
    if (fn[1] && $urandom_range(0, 3) != 0) begin
      // keep most divides in range
      if (w) dx = (opnd == 0) ? 16'h0 : dx % (opnd[14:0] + 16'h1);
      else ax[15:8] = (opnd[7:0] == 0) ? 8'h0 : ax[15:8] % (opnd[6:0] + 8'h1);
    end
    if ($urandom_range(0, 15) == 0) opnd = 16'h0;
    it = {fn, w, opnd, ax, dx};
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) item_num <= item_num + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("x86_multiply_divide_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = $urandom_range(0, 99);
      if (item_num == 200 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
      end
      out_stall <= !calm && n < 24;
      @(negedge clk);
    end
  end

  initial begin
    logic [50:0] it;
    int total;
    total = directed.size() + 750;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < total; i++) begin
      calm = (i > 400 && i < 500);
      while (!calm && $urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      if (i < directed.size()) it = directed[i];
      else next_item(it);
      {in_func, in_word_size, in_operand, in_ax_in, in_dx_in} <= it;
      in_valid <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("x86_multiply_divide_unit regression: pass");
    else $display("x86_multiply_divide_unit regression: fail");
    $finish;
  end

endmodule
